// ----- rtl/srps_pkg.sv -----
// Shared types and constants for the sound request priority slot block.
// Used by srps_ctrl, srps_dp and the top level; depends on nothing.
package srps_pkg;

    // Stream field layout, lowest bit first
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 32;
    localparam int PRIO_W      = 16;
    localparam int REF_W       = 24;
    localparam int CH_W        = 2;
    localparam int MASK_W      = 3;

    localparam int IN_CH_LO    = 0;
    localparam int IN_PRIO_LO  = 2;
    localparam int IN_REF_LO   = 18;
    localparam int IN_BUSY_LO  = 42;
    localparam int IN_LOOP_LO  = 45;

    localparam logic ACT_REQUEST = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clr;
        logic start;
        logic scan;
        logic emit;
        logic next_ch;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic in_bad;
        logic scan_done;
        logic out_free;
        logic more;
    } t_stat;

endpackage

// ----- rtl/srps_ctrl.sv -----
// Sequencer for the slot block: clear pass, accept, scan, result hand-off.
// Depends on srps_pkg.
module srps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  srps_pkg::t_stat i_stat,
    output srps_pkg::t_cmd  o_cmd
);

    srps_pkg::t_state r_state;
    srps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srps_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            srps_pkg::ST_CLEAR: begin
                if (i_stat.clr_done) n_state = srps_pkg::ST_IDLE;
            end
            srps_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_bad ? srps_pkg::ST_EMIT : srps_pkg::ST_SCAN;
                end
            end
            srps_pkg::ST_SCAN: begin
                if (i_stat.scan_done) n_state = srps_pkg::ST_EMIT;
            end
            srps_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.more ? srps_pkg::ST_SCAN : srps_pkg::ST_IDLE;
                end
            end
            default: n_state = srps_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            srps_pkg::ST_CLEAR: begin
                o_cmd.clr = 1'b1;
            end
            srps_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            srps_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            srps_pkg::ST_EMIT: begin
                o_cmd.emit    = i_stat.out_free;
                o_cmd.next_ch = i_stat.out_free & i_stat.more;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/srps_dp.sv -----
// Datapath: slot memory, head pointers, scan pipeline and output register.
// Depends on srps_pkg; driven by commands from srps_ctrl.
module srps_dp #(
    parameter int CHANNELS = 3,
    parameter int SLOTS    = 16,
    parameter int REF_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srps_pkg::t_cmd                    i_cmd,
    output srps_pkg::t_stat                   o_stat,
    input  logic [srps_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic                              i_in_tick,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [srps_pkg::OUT_DATA_W-1:0]   o_out_data,
    output logic                              o_out_last
);

    localparam int DEPTH = CHANNELS * SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RW    = (REF_BITS < srps_pkg::REF_W) ? REF_BITS : srps_pkg::REF_W;
    localparam int WW    = 1 + srps_pkg::PRIO_W + RW;

    localparam logic [SW-1:0]  LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CHW-1:0] LAST_CH   = CHW'(CHANNELS - 1);
    localparam logic [AW-1:0]  SLOTS_A   = AW'(SLOTS);

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    logic [WW-1:0] r_mem [DEPTH];
    logic [WW-1:0] r_rd;

    // item
    logic                        r_tick;
    logic [srps_pkg::CH_W-1:0]   r_req_ch;
    logic [srps_pkg::PRIO_W-1:0] r_prio;
    logic [RW-1:0]               r_note;
    logic [srps_pkg::MASK_W-1:0] r_busy;
    logic [srps_pkg::MASK_W-1:0] r_loop;

    // scan
    logic [CHW-1:0] r_ch;
    logic [SW-1:0]  r_pos;
    logic [SW-1:0]  r_cnt;
    logic           r_iss_on;
    logic           r_pv;
    logic           r_plast;
    logic [AW-1:0]  r_paddr;
    logic [SW-1:0]  r_pslot;
    logic           r_hit;
    logic           r_found;
    logic [RW-1:0]  r_fnote;
    logic [SW-1:0]  r_fslot;

    logic [SW-1:0]  r_head [CHANNELS];
    logic [AW-1:0]  r_clr;

    logic                              r_out_valid;
    logic [srps_pkg::OUT_DATA_W-1:0]   r_out_data;
    logic                              r_out_last;

    logic [srps_pkg::CH_W-1:0]   in_ch;
    logic                        in_bad;
    logic [CHW-1:0]              start_ch;
    logic [CHW-1:0]              step_ch;
    logic [AW-1:0]               rd_addr;
    logic                        rd_v;
    logic [srps_pkg::PRIO_W-1:0] rd_prio;
    logic [RW-1:0]               rd_note;
    logic                        hit_now;
    logic                        we;
    logic [AW-1:0]               wa;
    logic [WW-1:0]               wd;
    logic [7:0]                  busy_ext;
    logic [7:0]                  loop_ext;
    logic                        st;
    logic                        out_free;

    assign in_ch    = i_in_data[srps_pkg::IN_CH_LO +: srps_pkg::CH_W];
    assign in_bad   = (i_in_tick == srps_pkg::ACT_REQUEST) && (4'(in_ch) >= 4'(CHANNELS));
    assign start_ch = ((i_in_tick == srps_pkg::ACT_TICK) || in_bad) ? '0 : CHW'(in_ch);
    assign step_ch  = r_ch + 1'b1;

    assign rd_addr = AW'(r_ch) * SLOTS_A + AW'(r_pos);
    assign rd_v    = r_rd[WW-1];
    assign rd_prio = r_rd[WW-2:RW];
    assign rd_note = r_rd[RW-1:0];
    assign hit_now = !rd_v || (r_prio > rd_prio);

    always_comb begin
        we = 1'b0;
        wa = r_paddr;
        wd = {1'b0, rd_prio, rd_note};
        if (i_cmd.clr) begin
            we = 1'b1;
            wa = r_clr;
            wd = '0;
        end else if (i_cmd.scan && r_pv) begin
            if (r_tick == srps_pkg::ACT_TICK) begin
                we = 1'b1;
            end else if (hit_now) begin
                we = 1'b1;
                wd = {1'b1, r_prio, r_note};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (i_cmd.scan && r_iss_on) r_rd <= r_mem[rd_addr];
    end

    assign busy_ext = 8'(r_busy);
    assign loop_ext = 8'(r_loop);
    assign st       = (r_tick == srps_pkg::ACT_TICK) && r_found
                      && (!busy_ext[r_ch] || loop_ext[r_ch]);
    assign out_free = !r_out_valid || i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_iss_on    <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) r_head[c] <= '0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + 1'b1;
            if (i_cmd.start || i_cmd.next_ch) begin
                r_iss_on <= 1'b1;
                r_pv     <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pv <= r_iss_on;
                if (r_iss_on && r_cnt == LAST_SLOT) r_iss_on <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (st) r_head[r_ch] <= next_slot(r_fslot);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_tick   <= i_in_tick;
            r_req_ch <= in_ch;
            r_prio   <= i_in_data[srps_pkg::IN_PRIO_LO +: srps_pkg::PRIO_W];
            r_note   <= i_in_data[srps_pkg::IN_REF_LO +: RW];
            r_busy   <= i_in_data[srps_pkg::IN_BUSY_LO +: srps_pkg::MASK_W];
            r_loop   <= i_in_data[srps_pkg::IN_LOOP_LO +: srps_pkg::MASK_W];
            r_ch     <= start_ch;
            r_pos    <= r_head[start_ch];
        end else if (i_cmd.next_ch) begin
            r_ch  <= step_ch;
            r_pos <= r_head[step_ch];
        end
        if (i_cmd.start || i_cmd.next_ch) begin
            r_cnt   <= '0;
            r_hit   <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.scan) begin
            if (r_iss_on) begin
                r_pos   <= next_slot(r_pos);
                r_cnt   <= r_cnt + 1'b1;
                r_plast <= (r_cnt == LAST_SLOT);
                r_paddr <= rd_addr;
                r_pslot <= r_pos;
            end
            if (r_pv) begin
                if (r_tick == srps_pkg::ACT_TICK) begin
                    if (rd_v && !r_found) begin
                        r_found <= 1'b1;
                        r_fnote <= rd_note;
                        r_fslot <= r_pslot;
                    end
                end else if (hit_now) begin
                    r_hit <= 1'b1;
                end
            end
        end
        if (i_cmd.emit) begin
            r_out_data <= {4'b0000,
                           st ? srps_pkg::REF_W'(r_fnote) : {srps_pkg::REF_W{1'b0}},
                           st,
                           (r_tick == srps_pkg::ACT_REQUEST) && r_hit,
                           (r_tick == srps_pkg::ACT_TICK) ? srps_pkg::CH_W'(r_ch) : r_req_ch};
            r_out_last <= (r_tick == srps_pkg::ACT_REQUEST) || (r_ch == LAST_CH);
        end
    end

    always_comb begin
        o_stat.clr_done  = (r_clr == LAST_ADDR);
        o_stat.in_bad    = in_bad;
        o_stat.scan_done = r_pv && (r_plast || ((r_tick == srps_pkg::ACT_REQUEST) && hit_now));
        o_stat.out_free  = out_free;
        o_stat.more      = (r_tick == srps_pkg::ACT_TICK) && (r_ch != LAST_CH);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

// ----- rtl/sound_request_priority_slots_top.sv -----
// Top level of the sound request priority slot block.
// Depends on srps_pkg, srps_ctrl and srps_dp.
//
//  channel  | dir | handshake              | content
//  ---------+-----+------------------------+-----------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | note request or playback tick
//  m_axis   | out | m_axis_tvalid/tready   | one result per request, one per
//           |     |                        | channel per tick, tlast on final
//
// A request scans at most SLOTS slots of its channel (one slot memory read per
// cycle on the scan); a tick scans every slot of every channel.
// After reset a clearing pass over all CHANNELS*SLOTS slots runs with tready low.
// One item is in work at a time; the output register lets the next item be
// taken while the last result waits, and a stalled output holds the scan.
module sound_request_priority_slots_top #(
    parameter int CHANNELS = 3,
    parameter int SLOTS    = 16,
    parameter int REF_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // channel[1:0], priority_req[17:2], note_ref[41:18],
    // busy_mask[44:42], looping_mask[47:45]
    input  logic [srps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_channel[1:0], accepted[2], started[3], started_ref[27:4], zero[31:28]
    output logic [srps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

    srps_pkg::t_cmd  cmd;
    srps_pkg::t_stat stat;

    srps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    srps_dp #(
        .CHANNELS (CHANNELS),
        .SLOTS    (SLOTS),
        .REF_BITS (REF_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_in_tick   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule
